/* sv/rcp_pkg.sv */
// Shared types, constants and helpers for the rectangle canvas painter.
package rcp_pkg;

  localparam int MAX_DIM    = 512;
  localparam int DIM_BITS   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_BITS   = DIM_BITS + 1;
  localparam int ADDR_BITS  = 2 * DIM_BITS;
  localparam int DEPTH      = 1 << ADDR_BITS;
  localparam int CHAR_BITS  = 8;
  localparam int CFG_BITS   = 10;
  localparam int UNIT_SHIFT = 8;
  localparam int COORD_BITS = 35;

  localparam logic signed [COORD_BITS-1:0] ONE_UNIT = COORD_BITS'(1 << UNIT_SHIFT);

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_DRAW  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SIZE    = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BG     = 2'd2;

  localparam logic [CFG_BITS-1:0]  WIDTH_RST  = 10'd512;
  localparam logic [CFG_BITS-1:0]  HEIGHT_RST = 10'd512;
  localparam logic [CHAR_BITS-1:0] BG_RST     = 8'd32;

  typedef struct packed {
    logic [1:0]        action;
    logic              outline_only;
    logic signed [31:0] rect_left;
    logic signed [31:0] rect_top;
    logic signed [31:0] rect_width;
    logic signed [31:0] rect_height;
    logic [7:0]        paint_char;
    logic [8:0]        cell_row;
    logic [8:0]        cell_col;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] cell_value;
  } response_t;

  typedef struct packed {
    logic                  clear;
    logic                  outline;
    logic [CHAR_BITS-1:0]  fill_char;
    logic signed [31:0]    x;
    logic signed [31:0]    y;
    logic signed [31:0]    w;
    logic signed [31:0]    h;
  } sweep_job_t;

  typedef struct packed {
    logic                  en;
    logic [ADDR_BITS-1:0]  addr;
    logic [CHAR_BITS-1:0]  data;
  } ram_wr_t;

  function automatic logic signed [COORD_BITS-1:0] sx(input logic signed [31:0] v);
    return COORD_BITS'(v);
  endfunction

  function automatic logic [CNT_BITS-1:0] sat_dim(input logic [CFG_BITS-1:0] v);
    if (32'(v) > MAX_DIM) begin
      return CNT_BITS'(MAX_DIM);
    end
    return CNT_BITS'(v);
  endfunction

endpackage

/* sv/rectangle_canvas_painter.sv */
// Top level of the rectangle canvas painter: control, configuration and canvas memory.
// A request is taken when start is high and busy is low. Clear and draw walk every
// cell in use (rows by cols, the configured sizes capped at MAX_DIM) and write each
// cell that is painted, every cell for a clear, before they answer; a read answers
// from the RAM; a rejected draw, a read outside the canvas, a clear or draw on an
// empty canvas and an unused action answer in the next cycle. The answer is
// on response for exactly one cycle with done high and must be captured then.
module rectangle_canvas_painter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  rcp_pkg::request_t             request,
  output logic                          done,
  output rcp_pkg::response_t            response,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [rcp_pkg::CFG_BITS-1:0]  cfg_data
);
  import rcp_pkg::*;

  typedef enum logic [2:0] {
    T_IDLE  = 3'b001,
    T_SWEEP = 3'b010,
    T_READ  = 3'b100
  } top_state_t;

  top_state_t state;
  logic [CFG_BITS-1:0]  canvas_width;
  logic [CFG_BITS-1:0]  canvas_height;
  logic [CHAR_BITS-1:0] background_char;
  logic [CNT_BITS-1:0]  rows, cols;
  logic accept, empty, size_ok, outside, go, rd_en, finished;
  sweep_job_t job;
  ram_wr_t    wr;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [CHAR_BITS-1:0] rd_data;

  assign busy      = (state != T_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    rows    = sat_dim(canvas_height);
    cols    = sat_dim(canvas_width);
    accept  = start && !busy;
    empty   = (rows == '0) || (cols == '0);
    size_ok = (request.rect_width > 0) && (request.rect_height > 0);
    outside = (32'(request.cell_row) >= 32'(rows)) || (32'(request.cell_col) >= 32'(cols));
    go      = accept && !empty &&
              ((request.action == ACT_CLEAR) || ((request.action == ACT_DRAW) && size_ok));
    rd_en   = accept && (request.action == ACT_READ) && !outside;
    rd_addr = {DIM_BITS'(request.cell_row), DIM_BITS'(request.cell_col)};
    job.clear     = (request.action == ACT_CLEAR);
    job.outline   = request.outline_only;
    job.fill_char = (request.action == ACT_CLEAR) ? background_char : request.paint_char;
    job.x         = request.rect_left;
    job.y         = request.rect_top;
    job.w         = request.rect_width;
    job.h         = request.rect_height;
  end

  rcp_sweep u_sweep (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .job_in   (job),
    .rows     (rows),
    .cols     (cols),
    .wr       (wr),
    .finished (finished)
  );

  rcp_ram #(
    .WIDTH (CHAR_BITS),
    .DEPTH (DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= WIDTH_RST;
      canvas_height   <= HEIGHT_RST;
      background_char <= BG_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIDTH:  canvas_width    <= cfg_data;
        CFG_HEIGHT: canvas_height   <= cfg_data;
        CFG_BG:     background_char <= cfg_data[CHAR_BITS-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            response.cell_value <= '0;
            response.status     <= ST_OK;
            unique case (request.action)
              ACT_CLEAR: begin
                if (empty) begin
                  done <= 1'b1;
                end else begin
                  state <= T_SWEEP;
                end
              end
              ACT_DRAW: begin
                if (!size_ok) begin
                  response.status <= ST_SIZE;
                  done            <= 1'b1;
                end else if (empty) begin
                  done <= 1'b1;
                end else begin
                  state <= T_SWEEP;
                end
              end
              ACT_READ: begin
                if (outside) begin
                  response.status <= ST_OUTSIDE;
                  done            <= 1'b1;
                end else begin
                  state <= T_READ;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        T_SWEEP: begin
          if (finished) begin
            response.status     <= ST_OK;
            response.cell_value <= '0;
            done                <= 1'b1;
            state               <= T_IDLE;
          end
        end
        T_READ: begin
          response.status     <= ST_OK;
          response.cell_value <= rd_data;
          done                <= 1'b1;
          state               <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("accepted request neither in progress nor answered");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("response issued while still busy");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state == T_SWEEP))
    else $error("canvas write outside a sweep");

  a_finish_sweep: assert property (@(posedge clk) disable iff (rst)
    finished |-> (state == T_SWEEP))
    else $error("sweep finished with no sweep pending");

endmodule

/* sv/rcp_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
module rcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/rcp_sweep.sv */
// Raster sweep over the canvas: per-cell clear/paint decision and write stage.
module rcp_sweep (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  rcp_pkg::sweep_job_t       job_in,
  input  logic [rcp_pkg::CNT_BITS-1:0] rows,
  input  logic [rcp_pkg::CNT_BITS-1:0] cols,
  output rcp_pkg::ram_wr_t          wr,
  output logic                      finished
);
  import rcp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SETUP = 4'b0010,
    S_RUN   = 4'b0100,
    S_FLUSH = 4'b1000
  } sweep_state_t;

  sweep_state_t state;
  sweep_job_t   job;
  logic [DIM_BITS-1:0] r;
  logic [DIM_BITS-1:0] c;
  logic signed [COORD_BITS-1:0] x_lo, x_lo_edge, x_hi, x_hi_edge;
  logic signed [COORD_BITS-1:0] y_lo, y_lo_edge, y_hi, y_hi_edge;
  logic signed [COORD_BITS-1:0] py, px;
  logic in_r, in_c, edge_r, edge_c, paint;
  logic last_c, last_r;

  always_comb begin
    py     = signed'(COORD_BITS'({r, {UNIT_SHIFT{1'b0}}}));
    px     = signed'(COORD_BITS'({c, {UNIT_SHIFT{1'b0}}}));
    in_r   = (py >= y_lo) && (py <= y_hi);
    in_c   = (px >= x_lo) && (px <= x_hi);
    edge_r = (py < y_lo_edge) || (py > y_hi_edge);
    edge_c = (px < x_lo_edge) || (px > x_hi_edge);
    paint  = job.clear || (in_r && in_c && (!job.outline || edge_r || edge_c));
    last_c = (c == DIM_BITS'(cols - 1'b1));
    last_r = (r == DIM_BITS'(rows - 1'b1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wr.en    <= 1'b0;
      finished <= 1'b0;
    end else begin
      finished <= 1'b0;
      wr.en    <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            job   <= job_in;
            r     <= '0;
            c     <= '0;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          x_lo      <= sx(job.x);
          x_lo_edge <= sx(job.x) + ONE_UNIT;
          x_hi      <= sx(job.x) + sx(job.w);
          x_hi_edge <= sx(job.x) + sx(job.w) - ONE_UNIT;
          y_lo      <= sx(job.y);
          y_lo_edge <= sx(job.y) + ONE_UNIT;
          y_hi      <= sx(job.y) + sx(job.h);
          y_hi_edge <= sx(job.y) + sx(job.h) - ONE_UNIT;
          state     <= S_RUN;
        end
        S_RUN: begin
          wr.en   <= paint;
          wr.addr <= {r, c};
          wr.data <= job.fill_char;
          if (last_c) begin
            c <= '0;
            if (last_r) begin
              state <= S_FLUSH;
            end else begin
              r <= r + 1'b1;
            end
          end else begin
            c <= c + 1'b1;
          end
        end
        S_FLUSH: begin
          finished <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
